// ===== rtl/ppi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types and constants of the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int POOL_SIZE_DEF = 1024;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EMIT = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] REG_ACCEL_X  = 3'd0;
  localparam logic [2:0] REG_ACCEL_Y  = 3'd1;
  localparam logic [2:0] REG_JIT_VX   = 3'd2;
  localparam logic [2:0] REG_JIT_VY   = 3'd3;
  localparam logic [2:0] REG_JIT_SIZE = 3'd4;
  localparam logic [2:0] REG_SEED     = 3'd5;

  typedef enum logic [3:0] {
    ST_CLR,     // clearing pass after reset
    ST_IDLE,
    ST_RD,      // memory read issued
    ST_CHK,     // read data valid, slot decision
    ST_MUL,     // multiply step (shared unit)
    ST_WB,      // write back slot
    ST_EMIT,    // emit jitter steps
    ST_OUT      // result waiting
  } state_t;

  // one slot record
  typedef struct packed {
    logic        live;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] angle;
    logic [31:0] life;
    logic [31:0] size;
  } slot_t;

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -43'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

// ===== rtl/particle_pool_integrator.sv =====
// ----------------------------------------------------------------------------
// particle_pool_integrator
// Ring pool of particle slots with emit, tick (Euler) and read operations.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset a clearing pass writes every slot
// record inactive, one slot per cycle, so s_tready stays low until every
// slot is cleared. A tick walks every slot through a sequencer around one
// shared multiplier: an active slot passes memory read, read data check,
// four multiplies of the registered unit and write back, any other slot
// skips the multiplies. Emit runs four jitter draws through the same
// multiplier, then writes back; read and the unused opcode pass memory read
// and read data check before the result. The live flag is kept in each slot
// record of a single-port memory.
module particle_pool_integrator
  import ppi_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0] dt[25:2] pos_x_in[57:26] pos_y_in[89:58] vel_x_in[121:90]
  // vel_y_in[153:122] life_in[184:154] size_in[215:185] read_slot[225:216]
  input  logic [231:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // slot_out[9:0] active_count[20:10] alive[21] pos_x_out[53:22]
  // pos_y_out[85:54] vel_x_out[117:86] vel_y_out[149:118] angle_out[181:150]
  // life_out[213:182] start_size_out[245:214]
  output logic [247:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);

  // configuration
  logic [31:0] accel_x, accel_y;
  logic [30:0] jit_vx, jit_vy, jit_size;
  logic [15:0] lfsr;

  // transaction latch
  logic [1:0]  op;
  logic [23:0] dt;
  logic [31:0] in_px, in_py, in_vx, in_vy;
  logic [30:0] in_life, in_size;
  logic [9:0]  in_rs;

  state_t state, state_next;
  logic [AW-1:0] idx, next_slot;
  logic [CW-1:0] cnt, live_count;
  logic [2:0]  step;

  // memory
  slot_t mem [POOL_SIZE];
  slot_t rd, wr;
  logic  we;
  logic [AW-1:0] addr;
  logic  slot_act;

  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [41:0] mq;
  logic [247:0] res;

  ppi_mul u_mul (.clk(clk), .a(ma), .b(mb), .q(mq));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = res;
  assign addr = idx;

  // slot is live and still has life left
  assign slot_act = rd.live && (signed'(rd.life) > 0);

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wr;
    rd <= mem[addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: if (32'(idx) == POOL_SIZE - 1) state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid) begin
        state_next = (s_tdata[1:0] == OP_EMIT) ? ST_EMIT : ST_RD;
      end
      ST_RD: state_next = ST_CHK;
      ST_CHK: begin
        if (op != OP_TICK) state_next = ST_OUT;
        else state_next = slot_act ? ST_MUL : ST_WB;
      end
      ST_MUL: if (step == 3'd5) state_next = ST_WB;
      ST_WB: begin
        state_next = ((op == OP_EMIT) || (32'(idx) == POOL_SIZE - 1)) ? ST_OUT : ST_RD;
      end
      ST_EMIT: if (step == 3'd5) state_next = ST_WB;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operands per step; mq holds the product in the cycle after
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_MUL) begin
      case (step)
        3'd0: ma = 33'(signed'(rd.vel_x));
        3'd1: ma = 33'(signed'(rd.vel_y));
        3'd2: ma = 33'(signed'(accel_x));
        3'd3: ma = 33'(signed'(accel_y));
        default: ma = '0;
      endcase
      mb = signed'({1'b0, dt});
    end else if (state == ST_EMIT) begin
      case (step)
        3'd0: begin ma = {14'd0, TWO_PI_Q16}; mb = signed'({9'd0, lfsr}); end
        3'd1: begin ma = {2'b0, jit_vx};   mb = 25'(signed'({1'b0, lfsr}) - 17'sd32768); end
        3'd2: begin ma = {2'b0, jit_vy};   mb = 25'(signed'({1'b0, lfsr}) - 17'sd32768); end
        3'd3: begin ma = {2'b0, jit_size}; mb = 25'(signed'({1'b0, lfsr}) - 17'sd32768); end
        default: ma = '0;
      endcase
    end
  end

  // write back, or clear a record during the pass after reset
  assign we = (state == ST_WB) || (state == ST_CLR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      accel_x <= '0; accel_y <= '0;
      jit_vx <= '0; jit_vy <= '0; jit_size <= '0;
      lfsr <= 16'd1;
      next_slot <= '0;
      live_count <= '0;
      idx <= '0; step <= '0; cnt <= '0;
      wr <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_ACCEL_X:  accel_x <= cfg_wdata;
          REG_ACCEL_Y:  accel_y <= cfg_wdata;
          REG_JIT_VX:   jit_vx <= cfg_wdata[30:0];
          REG_JIT_VY:   jit_vy <= cfg_wdata[30:0];
          REG_JIT_SIZE: jit_size <= cfg_wdata[30:0];
          REG_SEED:     lfsr <= (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_CLR: idx <= (32'(idx) == POOL_SIZE - 1) ? '0 : idx + AW'(1);
        ST_IDLE: if (s_tvalid) begin
          op <= s_tdata[1:0];
          dt <= s_tdata[25:2];
          in_px <= s_tdata[57:26];   in_py <= s_tdata[89:58];
          in_vx <= s_tdata[121:90];  in_vy <= s_tdata[153:122];
          in_life <= s_tdata[184:154]; in_size <= s_tdata[215:185];
          in_rs <= s_tdata[225:216];
          step <= '0; cnt <= '0;
          if (s_tdata[1:0] == OP_EMIT) begin
            idx <= next_slot;
            lfsr <= lfsr_step(lfsr);
          end else if (s_tdata[1:0] == OP_READ) begin
            idx <= AW'(s_tdata[225:216]);
          end else begin
            idx <= '0;
          end
          res <= '0;
        end
        ST_RD: step <= '0;
        ST_CHK: begin
          step <= '0;
          if (op == OP_TICK) begin
            // a live slot out of life keeps its data and goes inactive
            wr <= {slot_act, rd[223:0]};
            if (slot_act) cnt <= cnt + CW'(1);
          end else begin
            res[20:10] <= 11'(live_count);
            if (op == OP_READ) begin
              res[9:0] <= in_rs;
              if (32'(in_rs) < POOL_SIZE) begin
                res[21] <= rd.live;
                res[245:22] <= {rd.size, rd.life, rd.angle, rd.vel_y, rd.vel_x,
                                rd.pos_y, rd.pos_x};
              end
            end
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          if (step == 3'd1) wr.pos_x <= sat32(43'(signed'(rd.pos_x)) + 43'(mq));
          if (step == 3'd2) wr.pos_y <= sat32(43'(signed'(rd.pos_y)) + 43'(mq));
          if (step == 3'd3) wr.vel_x <= sat32(43'(signed'(rd.vel_x)) + 43'(mq));
          if (step == 3'd4) wr.vel_y <= sat32(43'(signed'(rd.vel_y)) + 43'(mq));
          if (step == 3'd0) begin
            wr.angle <= rd.angle + {8'd0, dt};
            wr.life <= sat32(43'(signed'(rd.life)) - 43'(dt));
            wr.size <= rd.size;
          end
        end
        ST_EMIT: begin
          step <= step + 3'd1;
          if (step < 3'd3) lfsr <= lfsr_step(lfsr);
          if (step == 3'd0) begin
            wr.live <= 1'b1;
            wr.pos_x <= in_px; wr.pos_y <= in_py;
            wr.life <= {1'b0, in_life};
          end
          if (step == 3'd1) wr.angle <= mq[31:0];
          if (step == 3'd2) wr.vel_x <= sat32(43'(signed'(in_vx)) + 43'(mq));
          if (step == 3'd3) wr.vel_y <= sat32(43'(signed'(in_vy)) + 43'(mq));
          if (step == 3'd4) wr.size <= sat32(43'({1'b0, in_size}) + 43'(mq));
        end
        ST_WB: begin
          if (op == OP_EMIT) begin
            next_slot <= (32'(idx) == POOL_SIZE - 1) ? '0 : idx + AW'(1);
            res[9:0] <= 10'(idx);
            res[20:10] <= 11'(live_count);
            res[21] <= 1'b1;
            res[245:22] <= {wr.size, wr.life, wr.angle, wr.vel_y, wr.vel_x,
                            wr.pos_y, wr.pos_x};
          end else if (32'(idx) == POOL_SIZE - 1) begin
            live_count <= cnt;
            res[20:10] <= 11'(cnt);
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
      // opcode 3: the pool stays untouched; the result carries only the active count
    end
  end

  // ------------------------------------------------------------------------
  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !s_tready;
  endproperty
  a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("accept while result pending");

endmodule

// ===== rtl/ppi_mul.sv =====
// ----------------------------------------------------------------------------
// ppi_mul
// Registered signed 33x25 multiply, result shifted by 16 with floor.
// ----------------------------------------------------------------------------
module ppi_mul
  import ppi_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [24:0] b,
  output logic signed [41:0] q
);

  logic signed [57:0] prod;

  // arithmetic shift is floor division by 65536
  assign prod = a * b;

  always_ff @(posedge clk) begin
    q <= 42'(prod >>> 16);
  end

endmodule

// ===== dv/particle_pool_integrator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_integrator_test
// Drives emit, tick, read and unused-opcode transactions into the particle
// pool, tracks the pool in a local copy and compares every result field by
// field. Directed rows come first, then random phases under several
// register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module particle_pool_integrator_test;
  import ppi_pkg::*;

  localparam int NSLOT = 1024;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] OP_NONE = 2'd3;

  // result field positions in m_tdata, lowest first
  localparam int F_LO[10] = '{0, 10, 21, 22, 54, 86, 118, 150, 182, 214};
  localparam int F_W[10]  = '{10, 11, 1, 32, 32, 32, 32, 32, 32, 32};
  localparam string F_NAME[10] = '{"slot_out", "active_count", "alive", "pos_x_out",
    "pos_y_out", "vel_x_out", "vel_y_out", "angle_out", "life_out", "start_size_out"};

  typedef struct {
    logic [1:0]  op;
    logic [23:0] dt;
    logic [31:0] px, py, vx, vy;
    logic [30:0] life, size;
    logic [9:0]  rslot;
    bit          typed;    // slot/count/alive given by hand
    logic [9:0]  t_slot;
    logic [10:0] t_count;
    bit          t_alive;
  } particle_op_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [231:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [247:0] m_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  particle_pool_integrator uut (.*);

  always #10 clk = ~clk;

  // local pool copy
  bit          pool_live [NSLOT];
  logic [31:0] pool_px [NSLOT], pool_py [NSLOT], pool_vx [NSLOT], pool_vy [NSLOT];
  logic [31:0] pool_ang [NSLOT], pool_life [NSLOT], pool_size [NSLOT];
  int          next_idx;
  int          emitted;
  logic [10:0] live_total;
  logic [15:0] rng_state;
  logic [31:0] acc_x, acc_y;
  logic [30:0] span_vx, span_vy, span_size;

  logic [247:0] pending_results[$];
  int  fail_count = 0;
  bit  burst = 0;        // no gaps on either side
  bit  hold_req = 0;     // ask receiver for a long stall
  int  idle_cycles = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [15:0] next_rand();
    logic lsb;
    lsb = rng_state[0];
    rng_state = rng_state >> 1;
    if (lsb) rng_state = rng_state ^ LFSR_TAPS;
    return rng_state;
  endfunction

  function automatic longint spread(logic [30:0] span);
    longint c;
    c = longint'(next_rand()) - 32768;
    return (longint'({33'b0, span}) * c) >>> 16;
  endfunction

  function automatic logic [247:0] slot_result(int i, logic [9:0] sl);
    logic [247:0] r;
    r = '0;
    r[9:0] = sl;
    r[20:10] = live_total;
    r[21] = pool_live[i];
    r[53:22] = pool_px[i];
    r[85:54] = pool_py[i];
    r[117:86] = pool_vx[i];
    r[149:118] = pool_vy[i];
    r[181:150] = pool_ang[i];
    r[213:182] = pool_life[i];
    r[245:214] = pool_size[i];
    return r;
  endfunction

  // advance the pool copy by one transaction, return the expected result
  function automatic logic [247:0] pool_step(particle_op_t t);
    logic [247:0] r;
    longint d, ovx, ovy;
    int cnt;
    logic [63:0] a;
    r = '0;
    d = longint'({40'b0, t.dt});
    case (t.op)
      OP_TICK: begin
        cnt = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!pool_live[i]) continue;
          if (sx(pool_life[i]) <= 0) begin
            pool_live[i] = 0;
            continue;
          end
          ovx = sx(pool_vx[i]);
          ovy = sx(pool_vy[i]);
          pool_life[i] = clamp32(sx(pool_life[i]) - d);
          pool_px[i] = clamp32(sx(pool_px[i]) + ((ovx * d) >>> 16));
          pool_py[i] = clamp32(sx(pool_py[i]) + ((ovy * d) >>> 16));
          pool_vx[i] = clamp32(ovx + ((sx(acc_x) * d) >>> 16));
          pool_vy[i] = clamp32(ovy + ((sx(acc_y) * d) >>> 16));
          pool_ang[i] = pool_ang[i] + 32'(t.dt);
          cnt++;
        end
        live_total = 11'(cnt);
        r[20:10] = live_total;
      end
      OP_EMIT: begin
        pool_live[next_idx] = 1;
        pool_px[next_idx] = t.px;
        pool_py[next_idx] = t.py;
        a = 64'(next_rand()) * 64'(TWO_PI_Q16);
        pool_ang[next_idx] = 32'(a >> 16);
        pool_vx[next_idx] = clamp32(sx(t.vx) + spread(span_vx));
        pool_vy[next_idx] = clamp32(sx(t.vy) + spread(span_vy));
        pool_life[next_idx] = {1'b0, t.life};
        pool_size[next_idx] = clamp32(longint'({33'b0, t.size}) + spread(span_size));
        r = slot_result(next_idx, 10'(next_idx));
        next_idx = (next_idx + 1) % NSLOT;
        if (emitted < NSLOT) emitted++;
      end
      OP_READ: r = slot_result(t.rslot, t.rslot);
      default: r[20:10] = live_total;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // register writes, only while idle
  task automatic write_regs(logic [31:0] ax, logic [31:0] ay, logic [30:0] jvx,
                            logic [30:0] jvy, logic [30:0] jsz, logic [15:0] seed);
    logic [31:0] vals [6];
    logic [2:0]  idx [6];
    vals = '{ax, ay, {1'b0, jvx}, {1'b0, jvy}, {1'b0, jsz}, {16'b0, seed}};
    idx = '{REG_ACCEL_X, REG_ACCEL_Y, REG_JIT_VX, REG_JIT_VY, REG_JIT_SIZE, REG_SEED};
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1;
      cfg_addr <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 0;
    acc_x = ax;
    acc_y = ay;
    span_vx = jvx;
    span_vy = jvy;
    span_size = jsz;
    rng_state = (seed == 0) ? 16'd1 : seed;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // offer one transaction and record its expected result on acceptance
  task automatic send(particle_op_t t);
    int gap;
    logic [247:0] r;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, t.rslot, t.size, t.life, t.vy, t.vx, t.py, t.px, t.dt, t.op};
    do @(posedge clk); while (!s_tready);
    r = pool_step(t);
    if (t.typed) begin
      r[9:0] = t.t_slot;
      r[20:10] = t.t_count;
      r[21] = t.t_alive;
    end
    pending_results.push_back(r);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic particle_op_t random_op();
    particle_op_t t;
    int sel;
    t = '{op: OP_TICK, default: '0};
    t.dt = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4 << 16));
    t.px = pick32();
    t.py = pick32();
    t.vx = pick32();
    t.vy = pick32();
    t.life = ($urandom_range(0, 4) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 12 << 16));
    t.size = 31'($urandom());
    t.rslot = 10'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 8) t.op = OP_TICK;
    else if (sel < 52) t.op = OP_EMIT;
    else if (sel < 97) t.op = OP_READ;
    else t.op = OP_NONE;
    // only slots already written may be read
    if (t.op == OP_READ) begin
      if (emitted == 0) t.op = OP_EMIT;
      else t.rslot = 10'($urandom_range(0, emitted - 1));
    end
    return t;
  endfunction

  // receiver: random stalls, a long hold on request, field-by-field check
  initial begin
    int stall;
    logic [247:0] want;
    logic [31:0] g, w;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        stall = 400;
        hold_req = 0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        report("unexpected result", m_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < 10; k++) begin
          g = 32'(m_tdata >> F_LO[k]);
          w = 32'(want >> F_LO[k]);
          if (F_W[k] < 32) begin
            g &= (32'd1 << F_W[k]) - 1;
            w &= (32'd1 << F_W[k]) - 1;
          end
          if (g !== w) report(F_NAME[k], g, w);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    particle_op_t plan [$];
    particle_op_t t;
    for (int i = 0; i < NSLOT; i++) begin
      pool_live[i] = 0;
      pool_px[i] = '0; pool_py[i] = '0; pool_vx[i] = '0; pool_vy[i] = '0;
      pool_ang[i] = '0; pool_life[i] = '0; pool_size[i] = '0;
    end
    next_idx = 0;
    emitted = 0;
    live_total = '0;
    acc_x = '0; acc_y = '0;
    span_vx = '0; span_vy = '0; span_size = '0;
    rng_state = 16'd1;

    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows at reset settings
    plan.push_back('{op: OP_TICK, typed: 1, default: '0});
    plan.push_back('{op: OP_NONE, dt: 24'hFFFFFF, typed: 1, default: '0});
    plan.push_back('{op: OP_EMIT, px: 32'h7FFF_FFFF, py: 32'h8000_0000, vx: 32'h7FFF_FFFF,
                     vy: 32'h8000_0000, life: 31'h7FFF_FFFF, size: 31'h7FFF_FFFF,
                     rslot: 10'h3FF, typed: 1, t_slot: 10'd0, t_alive: 1, default: '0});
    plan.push_back('{op: OP_EMIT, typed: 1, t_slot: 10'd1, t_alive: 1, default: '0});
    plan.push_back('{op: OP_EMIT, px: 32'h0001_8000, py: 32'hFFFE_0000, vx: 32'h0000_4000,
                     vy: 32'hFFFF_C000, life: 31'h0003_0000, size: 31'h0001_0000,
                     typed: 1, t_slot: 10'd2, t_alive: 1, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd0, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd1, default: '0});
    // slot 1 has zero life and drops out; saturation on slot 0
    plan.push_back('{op: OP_TICK, dt: 24'hFFFFFF, typed: 1, t_count: 11'd2, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd0, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd1, typed: 1, t_slot: 10'd1, t_count: 11'd2,
                     t_alive: 0, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd2, default: '0});
    plan.push_back('{op: OP_TICK, dt: 24'h010000, default: '0});
    plan.push_back('{op: OP_NONE, typed: 1, t_count: 11'd1, default: '0});
    plan.push_back('{op: OP_TICK, dt: 24'h020000, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd2, default: '0});
    foreach (plan[i]) send(plan[i]);
    s_tvalid <= 0;
    drain();

    // extreme jitter and acceleration, then directed emits, a tick and reads
    write_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
               31'h7FFF_FFFF, 16'hFFFF);
    plan.delete();
    plan.push_back('{op: OP_EMIT, vx: 32'h7FFF_FFFF, vy: 32'h8000_0000, life: 31'h7FFF_FFFF,
                     size: 31'h7FFF_FFFF, default: '0});
    plan.push_back('{op: OP_EMIT, vx: 32'h8000_0000, vy: 32'h7FFF_FFFF, life: 31'h0001_0000,
                     default: '0});
    plan.push_back('{op: OP_TICK, dt: 24'h008000, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd3, default: '0});
    plan.push_back('{op: OP_READ, rslot: 10'd4, default: '0});
    foreach (plan[i]) send(plan[i]);
    s_tvalid <= 0;
    drain();

    // random phases under different settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_regs('0, '0, '0, '0, '0, 16'd1);
        1: write_regs(32'h8000_0000, 32'h7FFF_FFFF, 31'h0002_0000, 31'h0000_8000,
                      31'h0004_0000, 16'd0);
        2: write_regs(pick32(), pick32(), 31'($urandom()), 31'($urandom()),
                      31'($urandom()), 16'($urandom()));
        3: write_regs(32'h0000_8000, 32'hFFFF_0000, 31'h0001_0000, 31'h0001_0000,
                      31'h0001_0000, 16'hACE1);
        default: write_regs(32'($urandom_range(0, 1 << 17)) - (1 << 16), 32'hFFF6_0000,
                            31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)),
                            31'($urandom_range(0, 1 << 18)), 16'($urandom()));
      endcase
      for (int n = 0; n < 104; n++) begin
        burst = ((n % 40) >= 30);
        if (ph == 1 && n == 20) hold_req = 1;
        if (ph == 3 && n == 50) begin
          s_tvalid <= 0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        t = random_op();
        send(t);
      end
      burst = 0;
      s_tvalid <= 0;
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppi_pkg.sv
rtl/ppi_mul.sv
rtl/particle_pool_integrator.sv
dv/particle_pool_integrator_test.sv
